FILE: design/point_in_polygon_test_macros.svh
// Assertion macros for the point-in-polygon port checker (pip_port_checker).
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PIP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PIP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/pip_pkg.sv
`timescale 1ns / 1ps
// Package for the point-in-polygon test: sizes, codes, transaction and control types.
// Used by every module of the block except pip_ram; depends on nothing.
package pip_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int COORD_BITS   = 16;
	localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
	localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
	localparam int VCOUNT_BITS  = 7;
	localparam int DIFF_BITS    = COORD_BITS + 1;
	localparam int PROD_BITS    = 2 * DIFF_BITS + 1;
	localparam int SUM_BITS     = PROD_BITS + 1;

	// Request codes
	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	// Result status codes
	localparam logic [1:0] STATUS_STORED   = 2'd0;
	localparam logic [1:0] STATUS_ANSWERED = 2'd1;
	localparam logic [1:0] STATUS_DROPPED  = 2'd2;

	typedef struct packed {
		logic                         req_type;
		logic                         restart;
		logic signed [COORD_BITS-1:0] coord_x;
		logic signed [COORD_BITS-1:0] coord_y;
	} pip_in_t;

	typedef struct packed {
		logic [1:0]             status;
		logic                   inside_res;
		logic [VCOUNT_BITS-1:0] vertex_count;
	} pip_out_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} pip_vertex_t;

	// Commands from the sequencer to the edge unit
	typedef struct packed {
		logic clear;
		logic load_first;
		logic load_next;
		logic mul_a;
		logic mul_b;
		logic judge;
	} pip_edge_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LOAD,
		ST_MUL_A,
		ST_MUL_B,
		ST_JUDGE,
		ST_DONE
	} pip_state_t;

	// Magnitude of a vertex-minus-point difference; the most negative code never occurs.
	function automatic logic [DIFF_BITS-1:0] diff_mag(input logic signed [DIFF_BITS-1:0] v);
		logic [DIFF_BITS-1:0] m;
		m = v[DIFF_BITS-1] ? DIFF_BITS'(-v) : DIFF_BITS'(v);
		return m;
	endfunction

endpackage

FILE: design/point_in_polygon_test.sv
`timescale 1ns / 1ps
// Point-in-polygon test top level: sequencer, vertex RAM and edge unit.
// Depends on pip_pkg, pip_ram and pip_edge_unit.
//
// Usage:
//   in_valid/in_ready carry one request transaction: append a vertex (req_type 0,
//   restart empties the list first) or query a point (req_type 1).
//   out_valid/out_ready carry exactly one result transaction per request.
// Sequencing:
//   An append writes its vertex (unless the list is full) and then passes its result to the output
//   register; the next request is taken only once that result is loaded.
//   A query takes one vertex RAM read, then four steps per edge (load, two
//   passes through the shared multiplier, judge) including the closing edge;
//   with an empty list it skips the edge walk.
//   in_ready is high only while the sequencer is idle.
// Reset:
//   arst_n empties the vertex list and drops any pending result.
// Stall:
//   A result waits in the output register while out_ready is low; one further
//   request may be accepted meanwhile and its result holds in the sequencer
//   until the output register frees up.
module point_in_polygon_test (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pip_pkg::pip_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pip_pkg::pip_out_t out_data
);
	import pip_pkg::*;

	pip_state_t           state_q, state_d;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [CNT_BITS-1:0]  k_q;
	logic [CNT_BITS-1:0]  k_next;
	logic [CNT_BITS-1:0]  base;
	logic                 full;
	logic                 query_q;
	logic                 dropped_q;
	logic                 accept;
	logic                 load_out;
	logic                 out_valid_q;
	pip_out_t             out_data_q;
	pip_out_t             res;
	pip_edge_ctrl_t       ctrl;
	logic                 rd_en;
	logic [ADDR_BITS-1:0] rd_addr;
	logic [ADDR_BITS-1:0] next_idx;
	logic                 wr_en;
	pip_vertex_t          wr_vtx;
	pip_vertex_t          rd_vtx;
	logic                 parity;

	assign accept = in_valid && in_ready;

	// Append slot: restart empties the list before the vertex lands
	assign base   = in_data.restart ? '0 : cnt_q;
	assign full   = (base == CNT_BITS'(MAX_VERTICES));
	assign wr_vtx = '{x: in_data.coord_x, y: in_data.coord_y};

	// Next vertex of the walk; the last edge closes back to vertex zero
	assign k_next   = k_q + 1'b1;
	assign next_idx = (k_next == cnt_q) ? '0 : k_next[ADDR_BITS-1:0];

	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Next state and control
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ctrl     = '0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					if (in_data.req_type == REQ_QUERY) begin
						ctrl.clear = 1'b1;
						rd_en      = 1'b1;
						state_d    = (cnt_q == '0) ? ST_DONE : ST_FIRST;
					end else begin
						wr_en   = !full;
						state_d = ST_DONE;
					end
				end
			end
			ST_FIRST: begin
				ctrl.load_first = 1'b1;
				rd_en           = 1'b1;
				rd_addr         = next_idx;
				state_d         = ST_LOAD;
			end
			ST_LOAD: begin
				ctrl.load_next = 1'b1;
				state_d        = ST_MUL_A;
			end
			ST_MUL_A: begin
				ctrl.mul_a = 1'b1;
				state_d    = ST_MUL_B;
			end
			ST_MUL_B: begin
				ctrl.mul_b = 1'b1;
				state_d    = ST_JUDGE;
			end
			ST_JUDGE: begin
				ctrl.judge = 1'b1;
				if (k_q == cnt_q) begin
					state_d = ST_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = next_idx;
					state_d = ST_LOAD;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Vertex count, walk index and request kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			k_q       <= '0;
			query_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			if (accept) begin
				query_q   <= (in_data.req_type == REQ_QUERY);
				dropped_q <= (in_data.req_type == REQ_APPEND) && full;
				k_q       <= '0;
				if (in_data.req_type == REQ_APPEND && !full) begin
					cnt_q <= base + 1'b1;
				end
			end
			if (state_q == ST_FIRST || (state_q == ST_JUDGE && k_q != cnt_q)) begin
				k_q <= k_next;
			end
		end
	end

	// Assemble the result
	always_comb begin
		res              = '0;
		res.vertex_count = VCOUNT_BITS'(cnt_q);
		if (query_q) begin
			res.status     = STATUS_ANSWERED;
			res.inside_res = parity;
		end else if (dropped_q) begin
			res.status = STATUS_DROPPED;
		end else begin
			res.status = STATUS_STORED;
		end
	end

	// Output register valid: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	pip_ram #(
		.WIDTH($bits(pip_vertex_t)),
		.DEPTH(MAX_VERTICES)
	) u_vertex_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(base[ADDR_BITS-1:0]),
		.wr_data(wr_vtx),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_vtx)
	);

	pip_edge_unit u_edge (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.qx    (in_data.coord_x),
		.qy    (in_data.coord_y),
		.vtx   (rd_vtx),
		.parity(parity)
	);

endmodule

FILE: design/pip_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
module pip_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: design/pip_edge_unit.sv
`timescale 1ns / 1ps
// Edge unit: shifts vertices to the query point and tests one edge at a time
// with a single shared multiplier; keeps the crossing parity. Uses pip_pkg.
module pip_edge_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pip_pkg::pip_edge_ctrl_t               ctrl,
	input  logic signed [pip_pkg::COORD_BITS-1:0] qx,
	input  logic signed [pip_pkg::COORD_BITS-1:0] qy,
	input  pip_pkg::pip_vertex_t                  vtx,
	output logic                                  parity
);
	import pip_pkg::*;

	logic signed [COORD_BITS-1:0] qx_q, qy_q;
	logic signed [DIFF_BITS-1:0]  ax_q, ay_q, bx_q, by_q;
	logic signed [DIFF_BITS-1:0]  dx, dy;
	logic signed [DIFF_BITS-1:0]  op_s;
	logic        [DIFF_BITS-1:0]  op_u;
	logic signed [DIFF_BITS:0]    op_u_s;
	logic signed [PROD_BITS-1:0]  prod;
	logic signed [PROD_BITS-1:0]  prod_a_q, prod_b_q;
	logic signed [SUM_BITS-1:0]   sum;
	logic                         crosses;
	logic                         parity_q;

	// Shift the fetched vertex so the query point sits at the origin
	assign dx = DIFF_BITS'(vtx.x) - DIFF_BITS'(qx_q);
	assign dy = DIFF_BITS'(vtx.y) - DIFF_BITS'(qy_q);

	// Shared multiplier: ax*|by| first, then bx*|ay|
	assign op_s   = ctrl.mul_b ? bx_q : ax_q;
	assign op_u   = ctrl.mul_b ? diff_mag(ay_q) : diff_mag(by_q);
	assign op_u_s = {1'b0, op_u};
	assign prod   = op_s * op_u_s;

	// Crossing: ends strictly on opposite sides and ax*|by| + bx*|ay| > 0
	assign sum     = SUM_BITS'(prod_a_q) + SUM_BITS'(prod_b_q);
	assign crosses = (ay_q != '0) && (by_q != '0) && (ay_q[DIFF_BITS-1] != by_q[DIFF_BITS-1])
			&& !sum[SUM_BITS-1] && (sum != '0);

	// Datapath registers
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			qx_q <= qx;
			qy_q <= qy;
		end
		if (ctrl.load_first) begin
			ax_q <= dx;
			ay_q <= dy;
		end
		if (ctrl.load_next) begin
			bx_q <= dx;
			by_q <= dy;
		end
		if (ctrl.mul_a) begin
			prod_a_q <= prod;
		end
		if (ctrl.mul_b) begin
			prod_b_q <= prod;
		end
		// advance: the far end becomes the near end of the next edge
		if (ctrl.judge) begin
			ax_q <= bx_q;
			ay_q <= by_q;
		end
	end

	// Crossing parity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
		end else if (ctrl.clear) begin
			parity_q <= 1'b0;
		end else if (ctrl.judge && crosses) begin
			parity_q <= !parity_q;
		end
	end

	assign parity = parity_q;

endmodule

FILE: design/pip_port_checker.sv
`timescale 1ns / 1ps
// Port-level checker for point_in_polygon_test, bound to the top level.
// Uses pip_pkg and the assertion macros in point_in_polygon_test_macros.svh.
`include "point_in_polygon_test_macros.svh"

module pip_port_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input pip_pkg::pip_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input pip_pkg::pip_out_t out_data
);
	import pip_pkg::*;

	// A stalled result holds
	`PIP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

	// One request at a time: busy right after a transaction
	`PIP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request accepted while busy")

	// Appends never report inside
	`PIP_ASSERT_SAME(a_append_outside, out_valid && out_data.status != STATUS_ANSWERED, !out_data.inside_res, "inside set on append")

	// A vertex is dropped only with a full list
	`PIP_ASSERT_SAME(a_drop_full, out_valid && out_data.status == STATUS_DROPPED, out_data.vertex_count == VCOUNT_BITS'(MAX_VERTICES), "vertex dropped below capacity")

	// Status is a defined code
	`PIP_ASSERT_SAME(a_status_code, out_valid, out_data.status == STATUS_STORED || out_data.status == STATUS_ANSWERED || out_data.status == STATUS_DROPPED, "undefined status code")

endmodule

bind point_in_polygon_test pip_port_checker u_pip_port_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);

FILE: test/tb_point_in_polygon_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for point_in_polygon_test: directed and random vertex/query traffic,
// results scored against an in-bench crossing-parity predictor. Depends on pip_pkg and the RTL.
module tb_point_in_polygon_test;
	import pip_pkg::*;

	localparam int SETTLE_CYCLES = 4 * MAX_VERTICES + 8;
	localparam int TIMEOUT_NS    = 40_000_000;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	pip_in_t  in_data;
	logic     out_valid;
	logic     out_ready = 1'b0;
	pip_out_t out_data;

	// Polygon held by the predictor
	longint poly_x [MAX_VERTICES];
	longint poly_y [MAX_VERTICES];
	int     poly_count;

	pip_out_t answers_due [$];
	pip_out_t next_answer;

	int mismatches, items_sent, results_seen;
	int stored_total, dropped_total, queries_total, inside_total;

	// Flow control knobs
	bit tx_steady, rx_steady;
	int hold_request, hold_left, rx_gap_left, rx_pick;

	point_in_polygon_test i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Count one edge when its ends straddle the ray strictly and the crossing lies at x > 0
	function automatic bit ray_crosses(input longint ax, input longint ay,
		input longint bx, input longint by);
		longint mag_ay, mag_by;
		if (ay == 0 || by == 0 || ((ay < 0) == (by < 0)))
			return 1'b0;
		mag_ay = (ay < 0) ? -ay : ay;
		mag_by = (by < 0) ? -by : by;
		return (ax * mag_by + bx * mag_ay) > 0;
	endfunction

	// Apply one request to the predicted polygon and return the answer it produces
	function automatic pip_out_t predict_answer(input pip_in_t item);
		pip_out_t ans;
		longint px, py, ax, ay, bx, by;
		int j, crossings;
		ans = '0;
		px = longint'($signed(item.coord_x));
		py = longint'($signed(item.coord_y));
		if (item.req_type == REQ_APPEND) begin
			if (item.restart)
				poly_count = 0;
			if (poly_count < MAX_VERTICES) begin
				poly_x[poly_count] = px;
				poly_y[poly_count] = py;
				poly_count++;
				ans.status = STATUS_STORED;
				stored_total++;
			end else begin
				ans.status = STATUS_DROPPED;
				dropped_total++;
			end
		end else begin
			crossings = 0;
			for (int i = 0; i < poly_count; i++) begin
				j = (i + 1 == poly_count) ? 0 : i + 1;
				ax = poly_x[i] - px;
				ay = poly_y[i] - py;
				bx = poly_x[j] - px;
				by = poly_y[j] - py;
				if (ray_crosses(ax, ay, bx, by))
					crossings++;
			end
			ans.status     = STATUS_ANSWERED;
			ans.inside_res = crossings[0];
			queries_total++;
			inside_total += crossings[0];
		end
		ans.vertex_count = VCOUNT_BITS'(poly_count);
		return ans;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 100)
			$display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, what);
	endtask

	function automatic int coord_rand();
		logic signed [COORD_BITS-1:0] c;
		c = COORD_BITS'($urandom);
		return int'(c);
	endfunction

	function automatic int clamp_coord(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic int pick_send_gap();
		int pick;
		if (tx_steady)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one request transaction, hold it until accepted, then log its answer
	task automatic send_request(input logic req, input logic rst, input int x, input int y);
		pip_in_t item;
		int gap;
		item.req_type = req;
		item.restart  = rst;
		item.coord_x  = COORD_BITS'(x);
		item.coord_y  = COORD_BITS'(y);
		in_data  <= item;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		answers_due.push_back(predict_answer(item));
		items_sent++;
		gap = pick_send_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every logged answer has come back
	task automatic wait_for_answers();
		in_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random ready with short and long gaps, plus requested long hold-offs
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (rx_steady) begin
			out_ready <= 1'b1;
		end else if (rx_gap_left > 0) begin
			out_ready <= 1'b0;
			rx_gap_left--;
		end else begin
			rx_pick = $urandom_range(0, 99);
			if (rx_pick < 75) begin
				out_ready <= 1'b1;
			end else begin
				out_ready   <= 1'b0;
				rx_gap_left = (rx_pick < 96) ? $urandom_range(0, 2) : $urandom_range(10, 60);
			end
		end
	end

	// Score each result transaction against the oldest logged answer
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (answers_due.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				next_answer = answers_due.pop_front();
				if (out_data.status !== next_answer.status)
					report_mismatch($sformatf("status got %0d want %0d",
						out_data.status, next_answer.status));
				if (out_data.inside_res !== next_answer.inside_res)
					report_mismatch($sformatf("inside_res got %0d want %0d",
						out_data.inside_res, next_answer.inside_res));
				if (out_data.vertex_count !== next_answer.vertex_count)
					report_mismatch($sformatf("vertex_count got %0d want %0d",
						out_data.vertex_count, next_answer.vertex_count));
			end
		end
	end

	// Empty list, single vertex at the extremes, two-vertex list, restart flag on a query
	task automatic test_degenerate_lists();
		send_request(REQ_QUERY, 1'b1, 0, 0);
		send_request(REQ_APPEND, 1'b1, 32767, -32768);
		send_request(REQ_QUERY, 1'b0, 0, 0);
		send_request(REQ_APPEND, 1'b0, -32768, 32767);
		send_request(REQ_QUERY, 1'b0, -1, 0);
		send_request(REQ_QUERY, 1'b1, 0, 0);
		wait_for_answers();
	endtask

	// Small triangle: inside, outside, on a vertex, on an edge, a far corner
	task automatic test_triangle();
		send_request(REQ_APPEND, 1'b1, -100, -100);
		send_request(REQ_APPEND, 1'b0, 100, -100);
		send_request(REQ_APPEND, 1'b0, 0, 100);
		send_request(REQ_QUERY, 1'b0, 0, 0);
		send_request(REQ_QUERY, 1'b0, 0, -100);
		send_request(REQ_QUERY, 1'b0, 0, 100);
		send_request(REQ_QUERY, 1'b1, 200, 0);
		send_request(REQ_QUERY, 1'b0, -32768, 32767);
		wait_for_answers();
	endtask

	// Full-scale square and a slanted triangle that needs the exact product compare
	task automatic test_wide_coordinates();
		send_request(REQ_APPEND, 1'b1, -32768, -32768);
		send_request(REQ_APPEND, 1'b0, 32767, -32768);
		send_request(REQ_APPEND, 1'b0, 32767, 32767);
		send_request(REQ_APPEND, 1'b0, -32768, 32767);
		send_request(REQ_QUERY, 1'b0, 0, 0);
		send_request(REQ_QUERY, 1'b0, 32767, 0);
		send_request(REQ_QUERY, 1'b0, -32768, -32768);
		send_request(REQ_APPEND, 1'b1, -30000, -30000);
		send_request(REQ_APPEND, 1'b0, 30000, 30001);
		send_request(REQ_APPEND, 1'b0, -30000, 30000);
		send_request(REQ_QUERY, 1'b0, 0, 0);
		send_request(REQ_QUERY, 1'b0, -1, 0);
		send_request(REQ_QUERY, 1'b0, 1, 1);
		wait_for_answers();
	endtask

	// Fill the list, drop on overflow, query all edges, restart with a full list
	task automatic test_full_list();
		for (int k = 0; k < MAX_VERTICES; k++)
			send_request(REQ_APPEND, k == 0, coord_rand(), coord_rand());
		send_request(REQ_APPEND, 1'b0, 5, 5);
		send_request(REQ_QUERY, 1'b0, 0, 0);
		send_request(REQ_APPEND, 1'b0, -32768, 32767);
		send_request(REQ_APPEND, 1'b1, 1, 1);
		wait_for_answers();
	endtask

	// Hold the receiver off long enough that the block fills and stalls its input
	task automatic test_output_backpressure();
		hold_request = 300;
		tx_steady    = 1'b1;
		send_request(REQ_APPEND, 1'b1, 0, -50);
		send_request(REQ_APPEND, 1'b0, 50, 50);
		send_request(REQ_APPEND, 1'b0, -50, 50);
		send_request(REQ_QUERY, 1'b0, 0, 0);
		send_request(REQ_QUERY, 1'b0, 0, 100);
		send_request(REQ_APPEND, 1'b0, -60, -40);
		send_request(REQ_QUERY, 1'b0, 0, 10);
		send_request(REQ_QUERY, 1'b0, -55, 0);
		tx_steady = 1'b0;
		wait_for_answers();
	endtask

	// Run both sides without idling
	task automatic test_back_to_back();
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		for (int k = 0; k < 40; k++) begin
			if (k % 10 < 4)
				send_request(REQ_APPEND, k % 10 == 0, coord_rand() / 64, coord_rand() / 64);
			else
				send_request(REQ_QUERY, 1'b0, coord_rand() / 128, coord_rand() / 128);
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		wait_for_answers();
	endtask

	// Mostly well-formed polygons with queries around them, plus raw noise
	task automatic test_random_traffic(input int budget);
		int vx [MAX_VERTICES];
		int vy [MAX_VERTICES];
		int n, queries, span, cx, cy, sel, first, px, py;
		first = items_sent;
		while (items_sent - first < budget) begin
			tx_steady = ($urandom_range(0, 9) == 0);
			rx_steady = ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 99) < 80) begin
				sel = $urandom_range(0, 19);
				if (sel == 0)
					n = $urandom_range(30, MAX_VERTICES);
				else if (sel == 1)
					n = $urandom_range(1, 2);
				else
					n = $urandom_range(3, 10);
				case ($urandom_range(0, 3))
					0: span = 8;
					1: span = 300;
					2: span = 5000;
					default: span = 40000;
				endcase
				cx = (span == 40000) ? 0 : coord_rand();
				cy = (span == 40000) ? 0 : coord_rand();
				for (int k = 0; k < n; k++) begin
					vx[k] = clamp_coord(cx + int'($urandom_range(0, 2 * span)) - span);
					vy[k] = clamp_coord(cy + int'($urandom_range(0, 2 * span)) - span);
					send_request(REQ_APPEND, k == 0, vx[k], vy[k]);
				end
				queries = $urandom_range(1, 6);
				for (int q = 0; q < queries; q++) begin
					sel = $urandom_range(0, n - 1);
					px = clamp_coord(cx + int'($urandom_range(0, 2 * span)) - span);
					py = clamp_coord(cy + int'($urandom_range(0, 2 * span)) - span);
					case ($urandom_range(0, 5))
						0: begin
							px = vx[sel];
							py = vy[sel];
						end
						1: py = vy[sel];
						default: ;
					endcase
					send_request(REQ_QUERY, $urandom_range(0, 7) == 0, px, py);
				end
			end else begin
				n = $urandom_range(1, 5);
				for (int k = 0; k < n; k++)
					send_request(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0,
						coord_rand(), coord_rand());
			end
			if ($urandom_range(0, 24) == 0)
				wait_for_answers();
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		wait_for_answers();
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_degenerate_lists();
		test_triangle();
		test_wide_coordinates();
		test_full_list();
		test_output_backpressure();
		test_back_to_back();
		test_random_traffic(900);

		wait_for_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d requests: %0d vertices stored, %0d dropped,",
			items_sent, stored_total, dropped_total);
		$display("%0d queries (%0d inside); scored %0d results, %0d mismatches.",
			queries_total, inside_total, results_seen, mismatches);
		if (mismatches == 0)
			$display("point_in_polygon_test verification clean");
		else
			$display("point_in_polygon_test verification failed");
		$finish;
	end

	// Watchdog: end the run if traffic stops flowing
	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d answers outstanding.", answers_due.size());
		$display("point_in_polygon_test verification failed");
		$finish;
	end

endmodule
